### rtl/pfi_pkg.sv
// Shared types, constants and helpers for the particle force integrator.
// Used by pfi_front, pfi_back and particle_force_integrator_core.
`default_nettype none
package pfi_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int DAMP_BITS     = 16;
	localparam int DAMP_W        = 18;
	localparam logic [DAMP_W-1:0] DAMP_RESET = 18'd65536;
	localparam int QDEPTH        = 2;

	localparam logic [2:0] OP_FORCE   = 3'd0;
	localparam logic [2:0] OP_REPEL   = 3'd1;
	localparam logic [2:0] OP_ATTRACT = 3'd2;
	localparam logic [2:0] OP_CW      = 3'd3;
	localparam logic [2:0] OP_CCW     = 3'd4;
	localparam logic [2:0] OP_ARRIVE  = 3'd5;
	localparam logic [2:0] OP_DIRECT  = 3'd6;
	localparam logic [2:0] OP_UPDATE  = 3'd7;

	typedef enum logic [2:0] {
		CLS_FORCE,
		CLS_RADIAL,
		CLS_ARRIVE,
		CLS_DIRECT,
		CLS_UPDATE
	} cls_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_SIMPLE,
		BK_UPD_ADD,
		BK_UPD_MUL,
		BK_UPD_POS,
		BK_DIFF,
		BK_SQUARE,
		BK_SQRT,
		BK_RANGE,
		BK_DIVP,
		BK_DIVU,
		BK_MULK,
		BK_MULP,
		BK_APPLY,
		BK_DONE
	} bk_state_t;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [31:0] vec_x;
		logic signed [31:0] vec_y;
		logic signed [31:0] vec_z;
		logic [30:0]        reach;
		logic signed [31:0] strength;
		logic               has_partner;
	} item_t;

	typedef struct packed {
		logic signed [31:0] react_x;
		logic signed [31:0] react_y;
		logic signed [31:0] react_z;
		logic               in_range;
		logic signed [31:0] out_pos_x;
		logic signed [31:0] out_pos_y;
		logic signed [31:0] out_pos_z;
		logic               saturated;
	} result_t;

	typedef struct packed {
		cls_t  cls;
		item_t item;
	} job_t;

	typedef struct packed {
		logic               sat;
		logic signed [31:0] val;
	} sat32_t;

	// Clamp a wide signed value to the signed 32-bit range.
	function automatic sat32_t sat32(input logic signed [63:0] v);
		sat32_t r;
		if (v[63:31] != {33{v[63]}}) begin
			r.sat = 1'b1;
			r.val = v[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			r.sat = 1'b0;
			r.val = v[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/particle_force_integrator_core.sv
// Particle force integrator: one particle's position, velocity and force sum.
// Item beats enter the item channel, one result beat leaves per item; the damping
// register is written on the cfg channel, which is always ready.
// Items are queued (two deep) by the front part; the back part runs one item at
// a time. Force and direct steering update the force sum directly; an update
// adds the force sum to the velocity, damps it and moves the position. Arrival
// steering and radial or swirl events (Q16.16 at the default FRAC_BITS) run the
// 32-step square root and the one-bit-per-cycle divider for the reach ratio (radial events only) and the unit vector.
// Out-of-reach radial events end after the square root.
// The result register holds a beat while the receiver stalls; the back part
// then waits with its next result, and the queue keeps taking items until full.
// Reset clears position, velocity and force sum, sets damping to 1.0 and
// empties the queue. Depends on pfi_pkg, pfi_front and pfi_back.
`default_nettype none
module particle_force_integrator_core import pfi_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  item_t             item,
	output logic              result_valid,
	input  logic              result_stall,
	output result_t           result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [DAMP_W-1:0] cfg_data
);

	logic job_valid, job_pop;
	job_t job;

	assign cfg_ready = 1'b1;

	pfi_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.job_valid  (job_valid),
		.job_pop    (job_pop),
		.job        (job)
	);

	pfi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid & cfg_ready),
		.cfg_data     (cfg_data),
		.job_valid    (job_valid),
		.job_pop      (job_pop),
		.job          (job),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// The back part never takes a job from an empty queue.
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> job_valid)
		else $error("job taken from empty queue");

	// The back part takes no new job until it has left the idle state and returned to it.
	a_pop_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |=> !job_pop)
		else $error("jobs taken on consecutive cycles");

endmodule
`default_nettype wire

### rtl/pfi_front.sv
// Front part: accepts item beats, classifies the event and queues it.
// Depends on pfi_pkg.
`default_nettype none
module pfi_front import pfi_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_stall,
	input  item_t item,
	output logic  job_valid,
	input  logic  job_pop,
	output job_t  job
);

	localparam int PW = $clog2(QDEPTH);

	function automatic cls_t classify(input logic [2:0] op);
		cls_t c;
		unique case (op) inside
			OP_FORCE:                            c = CLS_FORCE;
			OP_REPEL, OP_ATTRACT, OP_CW, OP_CCW: c = CLS_RADIAL;
			OP_ARRIVE:                           c = CLS_ARRIVE;
			OP_DIRECT:                           c = CLS_DIRECT;
			default:                             c = CLS_UPDATE;
		endcase
		return c;
	endfunction

	job_t          fifo_q [QDEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;
	logic          push, pop;

	assign item_stall = (cnt_q == (PW+1)'(QDEPTH));
	assign job_valid  = (cnt_q != '0);
	assign job        = fifo_q[rp_q];
	assign push       = item_valid & ~item_stall;
	assign pop        = job_pop & job_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q].cls  <= classify(item.op);
			fifo_q[wp_q].item <= item;
		end
	end

endmodule
`default_nettype wire

### rtl/pfi_back.sv
// Back part: particle state, sequencer with iterative square root and divider,
// and the result register. Depends on pfi_pkg.
`default_nettype none
module pfi_back import pfi_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [DAMP_W-1:0] cfg_data,
	input  logic              job_valid,
	output logic              job_pop,
	input  job_t              job,
	output logic              result_valid,
	input  logic              result_stall,
	output result_t           result
);

	localparam int QW = FRAC_BITS + 1;
	localparam int UW = FRAC_BITS + 2;
	localparam int CW = $clog2(FRAC_BITS + 1);
	localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

	bk_state_t st_q, st_d;
	logic      res_load;

	logic [DAMP_W-1:0]  damp_q;
	logic signed [31:0] pos_q [3];
	logic signed [31:0] vel_q [3];
	logic signed [31:0] acc_q [3];

	job_t               job_q;
	logic signed [31:0] d_q [3];
	logic [63:0]        sum_q, sqn_q, sr_q, b_q;
	logic [31:0]        root_q;
	logic [1:0]         lane_q;
	logic [CW-1:0]      cnt_q;
	logic [32:0]        rem_q;
	logic [QW-1:0]      quo_q, pct_q;
	logic signed [UW-1:0] u_q [3];
	logic signed [32:0] k_q;
	logic signed [32:0] p_q [3];
	logic signed [50:0] up_q [3];
	logic signed [31:0] react_q [3];
	logic               hit_q, sat_q;
	result_t            res_q;
	logic               res_valid_q;

	// Combinational helpers.
	logic [31:0]        absd [3];
	logic [31:0]        den;
	logic               div_ge;
	logic [32:0]        rem_sub;
	logic [QW-1:0]      quo_nx;
	logic [63:0]        sq_t;
	logic               sq_ge;
	logic               in_reach;
	logic               is_radial;
	logic signed [QW+32:0] kp;
	logic signed [32:0] m2;
	logic signed [UW+32:0] mp [3];
	logic signed [33:0] own [3];
	logic signed [33:0] pe [3];
	logic signed [32:0] want [3];
	sat32_t             acc_nx [3];
	sat32_t             react_nx [3];
	sat32_t             simp_nx [3];
	sat32_t             vadd_nx [3];
	sat32_t             vdmp_nx [3];
	sat32_t             pnew_nx [3];
	sat32_t             diff_nx [3];
	logic signed [31:0] dl;

	assign is_radial = (job_q.cls == CLS_RADIAL);
	assign in_reach  = (job_q.item.reach == '0) || ({1'b0, root_q} <= {2'b0, job_q.item.reach});
	assign den       = (st_q == BK_DIVP) ? {1'b0, job_q.item.reach} : root_q;
	assign div_ge    = (rem_q >= {1'b0, den});
	assign rem_sub   = div_ge ? (rem_q - {1'b0, den}) : rem_q;
	assign quo_nx    = {quo_q[QW-2:0], div_ge};
	assign sq_t      = sr_q + b_q;
	assign sq_ge     = (sqn_q >= sq_t);
	assign kp        = $signed({1'b0, pct_q}) * job_q.item.strength;
	assign m2        = (job_q.cls == CLS_ARRIVE) ? $signed({1'b0, root_q}) : k_q;
	assign dl        = d_q[lane_q];

	always_comb begin
		logic signed [31:0] vin [3];
		vin[0] = job_q.item.vec_x;
		vin[1] = job_q.item.vec_y;
		vin[2] = job_q.item.vec_z;
		for (int i = 0; i < 3; i++) begin
			absd[i] = d_q[i][31] ? (32'd0 - d_q[i]) : d_q[i];
			mp[i]   = u_q[i] * m2;
			pe[i]   = 34'(p_q[i]);
			simp_nx[i] = (job_q.cls == CLS_DIRECT) ?
				sat32(64'(acc_q[i]) + 64'(vin[i]) - 64'(pos_q[i])) :
				sat32(64'(acc_q[i]) + 64'(vin[i]));
			diff_nx[i] = is_radial ? sat32(64'(pos_q[i]) - 64'(vin[i])) :
				sat32(64'(vin[i]) - 64'(pos_q[i]));
			vadd_nx[i] = sat32(64'(vel_q[i]) + 64'(acc_q[i]));
			vdmp_nx[i] = sat32(64'(up_q[i] >>> DAMP_BITS));
			pnew_nx[i] = sat32(64'(pos_q[i]) + 64'(vdmp_nx[i].val));
			want[i] = ({1'b0, root_q} < (33'd1 << FRAC_BITS)) ? p_q[i] : 33'(u_q[i]);
		end
		unique case (job_q.item.op)
			OP_REPEL: begin
				own[0] = pe[0]; own[1] = pe[1]; own[2] = pe[2];
			end
			OP_ATTRACT: begin
				own[0] = -pe[0]; own[1] = -pe[1]; own[2] = -pe[2];
			end
			OP_CW: begin
				own[0] = -pe[1]; own[1] = pe[0]; own[2] = '0;
			end
			default: begin
				own[0] = pe[1]; own[1] = -pe[0]; own[2] = '0;
			end
		endcase
		for (int i = 0; i < 3; i++) begin
			react_nx[i] = sat32(-64'(own[i]));
			acc_nx[i]   = is_radial ? sat32(64'(acc_q[i]) + 64'(own[i])) :
				sat32(64'(acc_q[i]) + 64'(want[i]) - 64'(vel_q[i]));
		end
	end

	// Next state and handshake outputs.
	always_comb begin
		st_d     = st_q;
		job_pop  = 1'b0;
		res_load = 1'b0;
		unique case (st_q)
			BK_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					unique case (job.cls) inside
						CLS_FORCE, CLS_DIRECT: st_d = BK_SIMPLE;
						CLS_UPDATE:            st_d = BK_UPD_ADD;
						default:               st_d = BK_DIFF;
					endcase
				end
			end
			BK_SIMPLE:  st_d = BK_DONE;
			BK_UPD_ADD: st_d = BK_UPD_MUL;
			BK_UPD_MUL: st_d = BK_UPD_POS;
			BK_UPD_POS: st_d = BK_DONE;
			BK_DIFF:    st_d = BK_SQUARE;
			BK_SQUARE:  if (lane_q == 2'd2) st_d = BK_SQRT;
			BK_SQRT:    if (b_q == 64'd1) st_d = BK_RANGE;
			BK_RANGE: begin
				if (is_radial) begin
					if (!in_reach) st_d = BK_DONE;
					else if (job_q.item.reach == '0) st_d = BK_DIVU;
					else st_d = BK_DIVP;
				end else begin
					st_d = (root_q == '0) ? BK_DONE : BK_DIVU;
				end
			end
			BK_DIVP: if (cnt_q == '0) st_d = BK_DIVU;
			BK_DIVU: begin
				if (root_q == '0) st_d = BK_MULK;
				else if (cnt_q == '0 && lane_q == 2'd2)
					st_d = is_radial ? BK_MULK : BK_MULP;
			end
			BK_MULK:  st_d = BK_MULP;
			BK_MULP:  st_d = BK_APPLY;
			BK_APPLY: st_d = BK_DONE;
			BK_DONE: begin
				if (!res_valid_q || !result_stall) begin
					res_load = 1'b1;
					st_d     = BK_IDLE;
				end
			end
			default: st_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= BK_IDLE;
			res_valid_q <= 1'b0;
			damp_q      <= DAMP_RESET;
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
				acc_q[i] <= '0;
			end
		end else begin
			st_q <= st_d;
			if (res_load) res_valid_q <= 1'b1;
			else if (!result_stall) res_valid_q <= 1'b0;
			if (cfg_we) damp_q <= cfg_data;
			for (int i = 0; i < 3; i++) begin
				unique case (st_q)
					BK_SIMPLE:  acc_q[i] <= simp_nx[i].val;
					BK_UPD_ADD: vel_q[i] <= vadd_nx[i].val;
					BK_UPD_POS: begin
						vel_q[i] <= vdmp_nx[i].val;
						pos_q[i] <= pnew_nx[i].val;
						acc_q[i] <= '0;
					end
					BK_APPLY: acc_q[i] <= acc_nx[i].val;
					default: ;
				endcase
			end
		end
	end

	// Working registers of the current job.
	always_ff @(posedge clk) begin
		unique case (st_q)
			BK_IDLE: begin
				job_q  <= job;
				hit_q  <= 1'b0;
				sat_q  <= 1'b0;
				lane_q <= '0;
				sum_q  <= '0;
				for (int i = 0; i < 3; i++) react_q[i] <= '0;
			end
			BK_SIMPLE:
				sat_q <= sat_q | simp_nx[0].sat | simp_nx[1].sat | simp_nx[2].sat;
			BK_UPD_ADD:
				sat_q <= sat_q | vadd_nx[0].sat | vadd_nx[1].sat | vadd_nx[2].sat;
			BK_UPD_MUL:
				for (int i = 0; i < 3; i++)
					up_q[i] <= 51'(vel_q[i]) * 51'($signed({1'b0, damp_q}));
			BK_UPD_POS:
				sat_q <= sat_q | vdmp_nx[0].sat | vdmp_nx[1].sat | vdmp_nx[2].sat
					| pnew_nx[0].sat | pnew_nx[1].sat | pnew_nx[2].sat;
			BK_DIFF:
				for (int i = 0; i < 3; i++) d_q[i] <= diff_nx[i].val;
			BK_SQUARE: begin
				sum_q  <= sum_q + 64'(dl * dl);
				lane_q <= lane_q + 2'd1;
				sqn_q  <= sum_q + 64'(dl * dl);
				sr_q   <= '0;
				b_q    <= 64'd1 << 62;
			end
			BK_SQRT: begin
				// One result bit per cycle, classic digit-by-digit root.
				if (sq_ge) begin
					sqn_q <= sqn_q - sq_t;
					sr_q  <= (sr_q >> 1) + b_q;
				end else begin
					sr_q <= sr_q >> 1;
				end
				b_q <= b_q >> 2;
				if (b_q == 64'd1) root_q <= sq_ge ? 32'((sr_q >> 1) + b_q) : 32'(sr_q >> 1);
			end
			BK_RANGE: begin
				hit_q  <= is_radial & in_reach;
				pct_q  <= ONE_Q;
				cnt_q  <= CW'(FRAC_BITS);
				lane_q <= '0;
				// Only a radial event with a finite reach divides by the reach first.
				rem_q  <= (is_radial && job_q.item.reach != '0) ? {1'b0, root_q} :
					{1'b0, absd[0]};
			end
			BK_DIVP: begin
				quo_q <= quo_nx;
				rem_q <= {rem_sub[31:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					pct_q <= ONE_Q - quo_nx;
					cnt_q <= CW'(FRAC_BITS);
					rem_q <= {1'b0, absd[0]};
				end
			end
			BK_DIVU: begin
				if (root_q == '0) begin
					for (int i = 0; i < 3; i++) u_q[i] <= '0;
				end else begin
					quo_q <= quo_nx;
					rem_q <= {rem_sub[31:0], 1'b0};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						u_q[lane_q] <= dl[31] ? -$signed({1'b0, quo_nx}) : $signed({1'b0, quo_nx});
						lane_q <= lane_q + 2'd1;
						cnt_q  <= CW'(FRAC_BITS);
						rem_q  <= (lane_q == 2'd0) ? {1'b0, absd[1]} : {1'b0, absd[2]};
					end
				end
			end
			BK_MULK: k_q <= 33'(kp >>> FRAC_BITS);
			BK_MULP:
				for (int i = 0; i < 3; i++) p_q[i] <= 33'(mp[i] >>> FRAC_BITS);
			BK_APPLY: begin
				sat_q <= sat_q | acc_nx[0].sat | acc_nx[1].sat | acc_nx[2].sat;
				if (is_radial && job_q.item.has_partner)
					for (int i = 0; i < 3; i++) react_q[i] <= react_nx[i].val;
			end
			default: ;
		endcase
		if (res_load) begin
			res_q.react_x   <= react_q[0];
			res_q.react_y   <= react_q[1];
			res_q.react_z   <= react_q[2];
			res_q.in_range  <= hit_q;
			res_q.out_pos_x <= pos_q[0];
			res_q.out_pos_y <= pos_q[1];
			res_q.out_pos_z <= pos_q[2];
			res_q.saturated <= sat_q;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule
`default_nettype wire
